>>> design/assert_macros.svh
// Assertion macros shared by the design files.
// In synthesis builds every macro expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/hbs_pkg.sv
package hbs_pkg;

  // Fixed field widths.
  localparam int CFG_DW   = 9;
  localparam int INDEX_W  = 16;
  localparam int SAMPLE_W = 32;
  localparam int COORD_W  = 17;
  localparam int FRAC_W   = 16;

  // Configuration register indexes.
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // Request modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Reset value of both size registers.
  localparam logic [CFG_DW-1:0] GRID_SIZE_RESET = 9'd256;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SAMPLE_W:0]   diff_t;
  typedef logic signed [SAMPLE_W+FRAC_W+1:0] prod_t;

endpackage

>>> design/heightmap_bilinear_sampler.sv
// Channel   Ports                                   Handshake
// request   in_mode/write_index/sample_value/s/t    start && !busy
// result    out_height_value                        out_valid, one cycle
// config    cfg_index, cfg_wdata                    cfg_we
//
// One request is taken every cycle while busy is low; a query result passes
// through the ten register stages of the pipeline.
// The two grid copies are each read at two addresses per cycle, so all four
// neighbors come out of one memory stage. Writes update both copies.
// busy is high only in the first cycle after reset; the receiver cannot
// stall, so the pipeline never holds. Reset is synchronous, active low.
`include "assert_macros.svh"

module heightmap_bilinear_sampler
  import hbs_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [INDEX_W-1:0]  in_write_index,
  input  logic [SAMPLE_W-1:0] in_sample_value,
  input  logic [COORD_W-1:0]  in_s_coord,
  input  logic [COORD_W-1:0]  in_t_coord,
  output logic                out_valid,
  output logic [SAMPLE_W-1:0] out_height_value,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata
);

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PSW   = COORD_W + WW;
  localparam int PTW   = COORD_W + HW;
  localparam int BW    = YW + WW;
  localparam int LAT   = 10;

  // Configuration registers.
  logic [CFG_DW-1:0] grid_width_r, grid_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GRID_SIZE_RESET;
      grid_height_r <= GRID_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata;
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata;
      endcase
    end
  end

  // Effective sizes: zero counts as one, oversize is clamped.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  always_comb begin
    if (grid_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(grid_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(grid_width_r);
    end
    if (grid_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(grid_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(grid_height_r);
    end
  end

  // Request handshake; busy covers the first cycle after reset.
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // Stage 1: scale both coordinates by the grid size.
  logic              v1_r, q1_r, wok1_r;
  logic [AW-1:0]     wa1_r;
  logic [SAMPLE_W-1:0] sv1_r;
  logic [PSW-1:0]    ps1_r;
  logic [PTW-1:0]    pt1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
    q1_r   <= (in_mode == MODE_QUERY);
    wok1_r <= (32'(in_write_index) < 32'(DEPTH));
    wa1_r  <= AW'(in_write_index);
    sv1_r  <= in_sample_value;
    ps1_r  <= PSW'(in_s_coord) * PSW'(w_eff);
    pt1_r  <= PTW'(in_t_coord) * PTW'(h_eff);
  end

  // Stage 2: wrap the integer parts and find the next column and row.
  // The integer part stays below twice the size, so one subtract wraps it.
  logic [WW:0]   ixs;
  logic [HW:0]   iys;
  logic [WW-1:0] xm_nxt, xinc, x1_nxt;
  logic [HW-1:0] ym_nxt, yinc, y1_nxt;

  always_comb begin
    ixs = ps1_r[PSW-1:FRAC_W];
    iys = pt1_r[PTW-1:FRAC_W];
    xm_nxt = (ixs >= {1'b0, w_eff}) ? WW'(ixs - {1'b0, w_eff}) : WW'(ixs);
    ym_nxt = (iys >= {1'b0, h_eff}) ? HW'(iys - {1'b0, h_eff}) : HW'(iys);
    xinc   = xm_nxt + WW'(1);
    yinc   = ym_nxt + HW'(1);
    x1_nxt = (xinc == w_eff) ? '0 : xinc;
    y1_nxt = (yinc == h_eff) ? '0 : yinc;
  end

  logic              v2_r, q2_r, wok2_r;
  logic [AW-1:0]     wa2_r;
  logic [SAMPLE_W-1:0] sv2_r;
  logic [XW-1:0]     x0_2_r, x1_2_r;
  logic [YW-1:0]     y0_2_r, y1_2_r;
  logic [FRAC_W-1:0] fx2_r, fy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    q2_r   <= q1_r;
    wok2_r <= wok1_r;
    wa2_r  <= wa1_r;
    sv2_r  <= sv1_r;
    x0_2_r <= XW'(xm_nxt);
    x1_2_r <= XW'(x1_nxt);
    y0_2_r <= YW'(ym_nxt);
    y1_2_r <= YW'(y1_nxt);
    fx2_r  <= ps1_r[FRAC_W-1:0];
    fy2_r  <= pt1_r[FRAC_W-1:0];
  end

  // Stage 3: row base addresses.
  logic              v3_r, q3_r, wok3_r;
  logic [AW-1:0]     wa3_r;
  logic [SAMPLE_W-1:0] sv3_r;
  logic [XW-1:0]     x0_3_r, x1_3_r;
  logic [BW-1:0]     base0_3_r, base1_3_r;
  logic [FRAC_W-1:0] fx3_r, fy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    q3_r      <= q2_r;
    wok3_r    <= wok2_r;
    wa3_r     <= wa2_r;
    sv3_r     <= sv2_r;
    x0_3_r    <= x0_2_r;
    x1_3_r    <= x1_2_r;
    base0_3_r <= BW'(y0_2_r) * BW'(w_eff);
    base1_3_r <= BW'(y1_2_r) * BW'(w_eff);
    fx3_r     <= fx2_r;
    fy3_r     <= fy2_r;
  end

  // Stage 4: grid memory. Copy A serves the upper row, copy B the lower.
  logic [AW-1:0] a00, a01, a10, a11;
  logic          mem_we;

  assign a00    = AW'(base0_3_r + BW'(x0_3_r));
  assign a01    = AW'(base0_3_r + BW'(x1_3_r));
  assign a10    = AW'(base1_3_r + BW'(x0_3_r));
  assign a11    = AW'(base1_3_r + BW'(x1_3_r));
  assign mem_we = v3_r && !q3_r && wok3_r;

  logic [SAMPLE_W-1:0] grid_a_r [DEPTH];
  logic [SAMPLE_W-1:0] grid_b_r [DEPTH];
  logic [SAMPLE_W-1:0] rd00_r, rd01_r, rd10_r, rd11_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_a_r[wa3_r] <= sv3_r;
    end
    rd00_r <= grid_a_r[a00];
    rd01_r <= grid_a_r[a01];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_b_r[wa3_r] <= sv3_r;
    end
    rd10_r <= grid_b_r[a10];
    rd11_r <= grid_b_r[a11];
  end

  logic              qv4_r;
  logic [FRAC_W-1:0] fx4_r, fy4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv4_r <= 1'b0;
    end else begin
      qv4_r <= v3_r && q3_r;
    end
    fx4_r <= fx3_r;
    fy4_r <= fy3_r;
  end

  // Stage 5: differences along each row.
  logic              qv5_r;
  diff_t             d0_5_r, d1_5_r;
  sample_t           s00_5_r, s10_5_r;
  logic [FRAC_W-1:0] fx5_r, fy5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv5_r <= 1'b0;
    end else begin
      qv5_r <= qv4_r;
    end
    d0_5_r  <= $signed({rd01_r[SAMPLE_W-1], rd01_r}) - $signed({rd00_r[SAMPLE_W-1], rd00_r});
    d1_5_r  <= $signed({rd11_r[SAMPLE_W-1], rd11_r}) - $signed({rd10_r[SAMPLE_W-1], rd10_r});
    s00_5_r <= $signed(rd00_r);
    s10_5_r <= $signed(rd10_r);
    fx5_r   <= fx4_r;
    fy5_r   <= fy4_r;
  end

  // Stage 6: weight the row differences by the column fraction.
  logic              qv6_r;
  prod_t             m0_6_r, m1_6_r;
  sample_t           s00_6_r, s10_6_r;
  logic [FRAC_W-1:0] fy6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv6_r <= 1'b0;
    end else begin
      qv6_r <= qv5_r;
    end
    m0_6_r  <= d0_5_r * $signed({1'b0, fx5_r});
    m1_6_r  <= d1_5_r * $signed({1'b0, fx5_r});
    s00_6_r <= s00_5_r;
    s10_6_r <= s10_5_r;
    fy6_r   <= fy5_r;
  end

  // Stage 7: row results; the floor shift is an arithmetic shift.
  logic              qv7_r;
  sample_t           r0_7_r, r1_7_r;
  logic [FRAC_W-1:0] fy7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv7_r <= 1'b0;
    end else begin
      qv7_r <= qv6_r;
    end
    r0_7_r <= s00_6_r + SAMPLE_W'(m0_6_r >>> FRAC_W);
    r1_7_r <= s10_6_r + SAMPLE_W'(m1_6_r >>> FRAC_W);
    fy7_r  <= fy6_r;
  end

  // Stage 8: difference between the two rows.
  logic              qv8_r;
  diff_t             d_8_r;
  sample_t           r0_8_r;
  logic [FRAC_W-1:0] fy8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv8_r <= 1'b0;
    end else begin
      qv8_r <= qv7_r;
    end
    d_8_r  <= $signed({r1_7_r[SAMPLE_W-1], r1_7_r}) - $signed({r0_7_r[SAMPLE_W-1], r0_7_r});
    r0_8_r <= r0_7_r;
    fy8_r  <= fy7_r;
  end

  // Stage 9: weight by the row fraction.
  logic    qv9_r;
  prod_t   m_9_r;
  sample_t r0_9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv9_r <= 1'b0;
    end else begin
      qv9_r <= qv8_r;
    end
    m_9_r  <= d_8_r * $signed({1'b0, fy8_r});
    r0_9_r <= r0_8_r;
  end

  // Stage 10: result register.
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] out_height_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= qv9_r;
    end
    out_height_value_r <= r0_9_r + SAMPLE_W'(m_9_r >>> FRAC_W);
  end

  assign out_valid        = out_valid_r;
  assign out_height_value = out_height_value_r;

  // Checks.
  `ASSERT_IMPLIES(a_result_from_query, clk, rst_n, out_valid,
    $past(start && !busy && in_mode == MODE_QUERY, LAT))
  `ASSERT_IMPLIES(a_col_in_range, clk, rst_n, v2_r && q2_r,
    (WW'(x0_2_r) < w_eff) && (WW'(x1_2_r) < w_eff))
  `ASSERT_IMPLIES(a_row_in_range, clk, rst_n, v2_r && q2_r,
    (HW'(y0_2_r) < h_eff) && (HW'(y1_2_r) < h_eff))
  `ASSERT_NEXT(a_busy_only_after_reset, clk, rst_n, 1'b1, !busy)

endmodule
